// ----- hdl/wmog_pkg.sv -----
// wmog_pkg: payload types, cell control type and constants of the windowed median block
// used by wmog_cell, window_median_with_outlier_guard and wmog_checker; no dependencies

package wmog_pkg;

    localparam int DATA_W = 16;

    // configuration register map (word index taken from paddr[2])
    localparam logic       REG_THRESHOLD = 1'b0;
    localparam logic [15:0] THRESHOLD_RESET = 16'd256;

    typedef struct packed {
        logic signed [DATA_W-1:0] sample;
        logic                     last;
    } t_in;

    typedef struct packed {
        logic signed [DATA_W-1:0] filtered;
        logic                     guard_tripped;
        logic                     overflowed;
    } t_out;

    // per-cycle command broadcast to every cell of the chain
    typedef struct packed {
        logic ins;   // insert the broadcast sample in order
        logic shl;   // shift the whole row one place toward cell 0
    } t_cell_ctrl;

endpackage

// ----- hdl/wmog_cell.sv -----
// wmog_cell: one slot of the sorted insertion chain
// depends on wmog_pkg (t_cell_ctrl, DATA_W)

module wmog_cell #(
    parameter int IDX = 0,
    parameter int CW  = 6
) (
    input  logic                                i_clk,
    input  wmog_pkg::t_cell_ctrl                i_ctrl,
    input  logic [CW-1:0]                       i_fill,
    input  logic signed [wmog_pkg::DATA_W-1:0]  i_sample,
    input  logic signed [wmog_pkg::DATA_W-1:0]  i_left_val,
    input  logic                                i_left_gt,
    input  logic signed [wmog_pkg::DATA_W-1:0]  i_right_val,
    output logic signed [wmog_pkg::DATA_W-1:0]  o_val,
    output logic                                o_gt
);

    logic signed [wmog_pkg::DATA_W-1:0] r_val;
    logic                               w_used;

    // an empty slot counts as larger than any sample
    assign w_used = CW'(IDX) < i_fill;
    assign o_gt   = !w_used || (r_val > i_sample);
    assign o_val  = r_val;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.shl) begin
            r_val <= i_right_val;
        end else if (i_ctrl.ins && o_gt) begin
            r_val <= i_left_gt ? i_left_val : i_sample;
        end
    end

endmodule

// ----- hdl/window_median_with_outlier_guard.sv -----
// window_median_with_outlier_guard: top level, sorted cell chain plus median and guard logic
// depends on wmog_pkg and wmog_cell

// Usage
// - input channel (i_in_valid / o_in_ready / i_in): one signed Q8.8 sample per request;
//   i_in.last closes the window. Samples beyond WINDOW_MAX are dropped and flagged.
// - output channel (o_out_valid / i_out_ready / o_out): one result per window, the median
//   or, when the first sample lies more than the threshold away from it, the first sample.
// - APB port: word 0 holds outlier_threshold (unsigned Q8.8, reset 1.0); pready is tied high.
// Timing
// - a sample that is not last is taken back to back, with no gap between samples
// - after a last sample the row of cells shifts toward cell 0 once per cycle until the
//   median sits in cells 0 and 1, then S_MED forms the median and S_GUARD applies the
//   guard into the output register
// Reset clears the window and the output valid flag, and sets the threshold to 1.0.
// When the receiver stalls the result holds in the output register; the next window is
// still taken, and only the guard step of that window waits for the register to free up.

module window_median_with_outlier_guard #(
    parameter int WINDOW_MAX = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    // sample requests
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  wmog_pkg::t_in  i_in,
    // result requests
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output wmog_pkg::t_out o_out,
    // configuration
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [2:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);

    localparam int DW = wmog_pkg::DATA_W;
    localparam int CW = $clog2(WINDOW_MAX + 1);                    // fill count
    localparam int KW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1; // shift count

    localparam logic [1:0] S_LOAD  = 2'd0;
    localparam logic [1:0] S_SHIFT = 2'd1;
    localparam logic [1:0] S_MED   = 2'd2;
    localparam logic [1:0] S_GUARD = 2'd3;

    logic [1:0]           r_state, n_state;
    logic [CW-1:0]        r_fill, n_fill;
    logic signed [DW-1:0] r_first, n_first;
    logic                 r_ovf, n_ovf;
    logic                 r_ovf_res, n_ovf_res;
    logic                 r_odd, n_odd;
    logic [KW-1:0]        r_k, n_k;
    logic signed [DW-1:0] r_med, n_med;
    logic [15:0]          r_thr, n_thr;
    logic                 r_out_valid, n_out_valid;
    wmog_pkg::t_out       r_out, n_out;

    logic                 w_acc;
    logic                 w_room;
    logic [CW-1:0]        w_n;
    logic [CW-1:0]        w_nm1;
    logic [KW-1:0]        w_k;
    logic signed [DW:0]   w_sum;
    logic signed [DW:0]   w_diff;
    logic [DW:0]          w_dist;
    logic                 w_guard;
    logic                 w_out_free;
    logic                 w_cfg_wr;
    wmog_pkg::t_cell_ctrl w_ctrl;

    // chain wiring: entry 0 is the left edge, entry i+1 is cell i's output,
    // the extra right entry mirrors the last cell so that it holds during a shift
    logic signed [DW-1:0] w_vl [0:WINDOW_MAX+1];
    logic                 w_gtl [0:WINDOW_MAX];

    assign o_in_ready = (r_state == S_LOAD);
    assign w_acc      = i_in_valid && o_in_ready;
    assign w_room     = r_fill < CW'(WINDOW_MAX);
    assign w_n        = r_fill + CW'(w_room);
    assign w_nm1      = w_n - CW'(1);
    assign w_k        = KW'(w_nm1 >> 1);   // shifts that bring the lower middle to cell 0

    assign w_ctrl.ins = w_acc && w_room;
    assign w_ctrl.shl = (r_state == S_SHIFT);

    assign w_vl[0]            = i_in.sample;
    assign w_gtl[0]           = 1'b0;
    assign w_vl[WINDOW_MAX+1] = w_vl[WINDOW_MAX];

    for (genvar gi = 0; gi < WINDOW_MAX; gi++) begin : g_cell
        wmog_cell #(
            .IDX (gi),
            .CW  (CW)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctrl      (w_ctrl),
            .i_fill      (r_fill),
            .i_sample    (i_in.sample),
            .i_left_val  (w_vl[gi]),
            .i_left_gt   (w_gtl[gi]),
            .i_right_val (w_vl[gi+2]),
            .o_val       (w_vl[gi+1]),
            .o_gt        (w_gtl[gi+1])
        );
    end

    // middle pair sits in cells 0 and 1 once shifting is done
    assign w_sum = {w_vl[1][DW-1], w_vl[1]} + {w_vl[2][DW-1], w_vl[2]};

    // distance of the first sample from the median, exact in 17 bits
    assign w_diff  = {r_first[DW-1], r_first} - {r_med[DW-1], r_med};
    assign w_dist  = w_diff[DW] ? (DW+1)'(-w_diff) : w_diff;
    assign w_guard = w_dist > {1'b0, r_thr};

    assign w_out_free = !r_out_valid || i_out_ready;

    // configuration port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;
    assign prdata   = (paddr[2] == wmog_pkg::REG_THRESHOLD) ? {16'd0, r_thr} : 32'd0;

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_first     = r_first;
        n_ovf       = r_ovf;
        n_ovf_res   = r_ovf_res;
        n_odd       = r_odd;
        n_k         = r_k;
        n_med       = r_med;
        n_thr       = r_thr;
        n_out_valid = r_out_valid;
        n_out       = r_out;

        if (w_cfg_wr && paddr[2] == wmog_pkg::REG_THRESHOLD) begin
            n_thr = pwdata[15:0];
        end

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_LOAD: begin
                if (w_acc) begin
                    if (r_fill == '0) begin
                        n_first = i_in.sample;
                    end
                    if (w_room) begin
                        n_fill = w_n;
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_in.last) begin
                        // close the window; the cells keep the sorted row
                        n_ovf_res = r_ovf || !w_room;
                        n_ovf     = 1'b0;
                        n_fill    = '0;
                        n_odd     = w_n[0];
                        n_k       = w_k;
                        n_state   = (w_k == '0) ? S_MED : S_SHIFT;
                    end
                end
            end
            S_SHIFT: begin
                n_k = r_k - KW'(1);
                if (r_k == KW'(1)) begin
                    n_state = S_MED;
                end
            end
            S_MED: begin
                // even count: floor of the pair mean by arithmetic shift
                n_med   = r_odd ? w_vl[1] : w_sum[DW:1];
                n_state = S_GUARD;
            end
            S_GUARD: begin
                if (w_out_free) begin
                    n_out.filtered      = w_guard ? r_first : r_med;
                    n_out.guard_tripped = w_guard;
                    n_out.overflowed    = r_ovf_res;
                    n_out_valid         = 1'b1;
                    n_state             = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_fill      <= '0;
            r_first     <= '0;
            r_ovf       <= 1'b0;
            r_thr       <= wmog_pkg::THRESHOLD_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_first     <= n_first;
            r_ovf       <= n_ovf;
            r_thr       <= n_thr;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_ovf_res <= n_ovf_res;
        r_odd     <= n_odd;
        r_k       <= n_k;
        r_med     <= n_med;
        r_out     <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// ----- hdl/wmog_checker.sv -----
// wmog_checker: port-level assertions for the windowed median block, with its bind
// depends on wmog_pkg and window_median_with_outlier_guard

module wmog_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           o_in_ready,
    input wmog_pkg::t_in  i_in,
    input logic           o_out_valid,
    input logic           i_out_ready,
    input wmog_pkg::t_out o_out
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("result changed while stalled");

    // closing a window always leaves the block busy in the next cycle
    a_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in.last |=> !o_in_ready)
        else $error("sample taken right after window close");

    // a new result only appears out of the busy phase of a window
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("result appeared without a closed window");

    // reset empties the output
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind window_median_with_outlier_guard wmog_checker u_wmog_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in        (i_in),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);
